// ===== rtl/core/gmfc_pkg.sv =====
// shared types and constants of the glyph mask format converter
// no dependencies; used by the top level and its checker

package gmfc_pkg;

    // mask output formats, as held in the mask_mode register
    typedef enum logic [1:0] {
        MODE_BILEVEL = 2'd0,
        MODE_A8      = 2'd1,
        MODE_LCD16   = 2'd2,
        MODE_LCD32   = 2'd3
    } t_mask_mode;

    // kind of input transaction, carried in tuser
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_TABLE = 1'b1;

    // table select codes of a table write
    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    // configuration register map (byte addresses)
    localparam int          ADDR_W        = 3;
    localparam logic [2:0]  ADDR_MODE     = 3'd0;
    localparam logic [2:0]  ADDR_PREBLEND = 3'd4;
    localparam t_mask_mode  MODE_RESET    = MODE_A8;

    // lookup table geometry, fixed by the 8 bit index field
    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

    // divide by three as multiply by reciprocal, exact for sums up to 765
    localparam int          GRAY_SUM_W  = 10;
    localparam logic [9:0]  GRAY_RECIP  = 10'd683;
    localparam int          GRAY_SHIFT  = 11;

    // opaque alpha byte of the ARGB8888 format
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  BIT_MSB      = 8'h80;

endpackage

// ===== rtl/core/glyph_mask_format_converter.sv =====
// glyph mask format converter, top level
// depends on gmfc_pkg; the three channel lookup tables live inside
//
// usage:
//   s-side stream: one transaction per source pixel or per table word.
//   tuser selects pixel (0) or table write (1); tlast marks the last pixel
//   of a glyph row. m-side stream: one mask word per result, tlast copies
//   the row end. bilevel mode gives one result per eight pixels or at row
//   end; table writes give none.
//   apb port: mask_mode at 0x0, preblend_enable at 0x4, write when idle.
// throughput: one transaction per cycle while the receiver keeps tready high;
//   from acceptance to tvalid an item passes a table read stage (registered
//   ram output) and then the result register.
// reset: clears the pipeline valids, the bilevel accumulator and position,
//   mask_mode to A8 and preblend off. table contents are undefined until
//   written; no clearing pass is run.
// stall: when the receiver holds tready low the result register holds and
//   the pipeline keeps taking items until both stages are full.

module glyph_mask_format_converter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input stream
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // tdata: red[7:0], green[15:8], blue[23:16], table_select[25:24],
    //        table_index[33:26], table_value[41:34], zero[47:42]
    input  logic [47:0]               i_s_tdata,
    // tuser: cmd[0]
    input  logic                      i_s_tuser,
    // tlast: last_in_row
    input  logic                      i_s_tlast,
    // output stream
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // tdata: mask_word[31:0]
    output logic [31:0]               o_m_tdata,
    // tlast: row_last
    output logic                      o_m_tlast,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [gmfc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    // field unpacking
    logic [7:0] s_red;
    logic [7:0] s_green;
    logic [7:0] s_blue;
    logic [1:0] s_sel;
    logic [7:0] s_idx;
    logic [7:0] s_val;

    assign s_red   = i_s_tdata[7:0];
    assign s_green = i_s_tdata[15:8];
    assign s_blue  = i_s_tdata[23:16];
    assign s_sel   = i_s_tdata[25:24];
    assign s_idx   = i_s_tdata[33:26];
    assign s_val   = i_s_tdata[41:34];

    // configuration registers
    gmfc_pkg::t_mask_mode r_mode;
    logic                 r_preblend;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= gmfc_pkg::MODE_RESET;
            r_preblend <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == gmfc_pkg::ADDR_PREBLEND[2]) begin
                r_preblend <= pwdata[0];
            end else begin
                r_mode <= gmfc_pkg::t_mask_mode'(pwdata[1:0]);
            end
        end
    end

    // register read back
    always_comb begin
        if (paddr[2] == gmfc_pkg::ADDR_PREBLEND[2]) begin
            prdata = {31'd0, r_preblend};
        end else begin
            prdata = {30'd0, r_mode};
        end
    end

    // pipeline flow control
    logic r_s1_valid;
    logic r_out_valid;
    logic out_en;
    logic s1_ready;
    logic accept;
    logic is_pixel;

    assign out_en     = !r_out_valid || i_m_tready;
    assign s1_ready   = !r_s1_valid || out_en;
    assign o_s_tready = s1_ready;
    assign accept     = i_s_tvalid && s1_ready;
    assign is_pixel   = (i_s_tuser == gmfc_pkg::CMD_PIXEL);

    // gray level: (r + g + b) / 3 by reciprocal multiply
    logic [gmfc_pkg::GRAY_SUM_W-1:0]   gray_sum;
    logic [2*gmfc_pkg::GRAY_SUM_W-1:0] gray_prod;
    logic [7:0]                        gray;

    assign gray_sum  = {2'd0, s_red} + {2'd0, s_green} + {2'd0, s_blue};
    assign gray_prod = gray_sum * gmfc_pkg::GRAY_RECIP;
    assign gray      = gray_prod[gmfc_pkg::GRAY_SHIFT+7:gmfc_pkg::GRAY_SHIFT];

    // bilevel packing state
    logic [7:0] r_bit_acc;
    logic [2:0] r_bit_pos;
    logic [7:0] n_bit_acc;
    logic       bit_emit;
    logic       bilevel_px;

    assign bilevel_px = accept && is_pixel && (r_mode == gmfc_pkg::MODE_BILEVEL);
    assign n_bit_acc  = r_bit_acc | (s_red & (gmfc_pkg::BIT_MSB >> r_bit_pos));
    assign bit_emit   = (r_bit_pos == 3'd7) || i_s_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_acc <= 8'd0;
            r_bit_pos <= 3'd0;
        end else if (bilevel_px) begin
            if (bit_emit) begin
                r_bit_acc <= 8'd0;
                r_bit_pos <= 3'd0;
            end else begin
                r_bit_acc <= n_bit_acc;
                r_bit_pos <= r_bit_pos + 3'd1;
            end
        end
    end

    // channel lookup tables, one write or one registered read per cycle each
    logic [7:0] red_mem   [gmfc_pkg::TABLE_DEPTH];
    logic [7:0] green_mem [gmfc_pkg::TABLE_DEPTH];
    logic [7:0] blue_mem  [gmfc_pkg::TABLE_DEPTH];
    logic [7:0] r_red_rd;
    logic [7:0] r_green_rd;
    logic [7:0] r_blue_rd;
    logic [gmfc_pkg::TABLE_AW-1:0] green_raddr;
    logic       tbl_wr;
    logic       tbl_rd;

    assign tbl_wr      = accept && !is_pixel;
    assign tbl_rd      = accept && is_pixel;
    assign green_raddr = (r_mode == gmfc_pkg::MODE_A8) ? gray : s_green;

    always_ff @(posedge i_clk) begin
        if (tbl_wr && s_sel == gmfc_pkg::SEL_RED) begin
            red_mem[s_idx] <= s_val;
        end
        if (tbl_rd) begin
            r_red_rd <= red_mem[s_red];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_wr && s_sel == gmfc_pkg::SEL_GREEN) begin
            green_mem[s_idx] <= s_val;
        end
        if (tbl_rd) begin
            r_green_rd <= green_mem[green_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_wr && s_sel == gmfc_pkg::SEL_BLUE) begin
            blue_mem[s_idx] <= s_val;
        end
        if (tbl_rd) begin
            r_blue_rd <= blue_mem[s_blue];
        end
    end

    // stage one: raw pixel fields beside the table read data
    gmfc_pkg::t_mask_mode r_s1_mode;
    logic [7:0]           r_s1_red;
    logic [7:0]           r_s1_green;
    logic [7:0]           r_s1_blue;
    logic [7:0]           r_s1_gray;
    logic [7:0]           r_s1_byte;
    logic                 r_s1_last;
    logic                 n_s1_valid;

    // a pixel makes a result unless it is a bilevel pixel inside a byte
    assign n_s1_valid = tbl_rd && !(r_mode == gmfc_pkg::MODE_BILEVEL && !bit_emit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= accept && n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_rd) begin
            r_s1_mode  <= r_mode;
            r_s1_red   <= s_red;
            r_s1_green <= s_green;
            r_s1_blue  <= s_blue;
            r_s1_gray  <= gray;
            r_s1_byte  <= n_bit_acc;
            r_s1_last  <= i_s_tlast;
        end
    end

    // format the mask word
    logic [7:0]  ch_red;
    logic [7:0]  ch_green;
    logic [7:0]  ch_blue;
    logic [7:0]  ch_gray;
    logic [31:0] n_word;

    assign ch_red   = r_preblend ? r_red_rd   : r_s1_red;
    assign ch_green = r_preblend ? r_green_rd : r_s1_green;
    assign ch_blue  = r_preblend ? r_blue_rd  : r_s1_blue;
    assign ch_gray  = r_preblend ? r_green_rd : r_s1_gray;

    always_comb begin
        case (r_s1_mode)
            gmfc_pkg::MODE_BILEVEL: begin
                n_word = {24'd0, r_s1_byte};
            end
            gmfc_pkg::MODE_A8: begin
                n_word = {24'd0, ch_gray};
            end
            gmfc_pkg::MODE_LCD16: begin
                n_word = {16'd0, ch_red[7:3], ch_green[7:2], ch_blue[7:3]};
            end
            gmfc_pkg::MODE_LCD32: begin
                n_word = {gmfc_pkg::ALPHA_OPAQUE, ch_red, ch_green, ch_blue};
            end
            default: begin
                n_word = 32'd0;
            end
        endcase
    end

    // result register
    logic [31:0] r_out_word;
    logic        r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_s1_valid) begin
            r_out_word <= n_word;
            r_out_last <= r_s1_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_word;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== rtl/core/gmfc_checker.sv =====
// port level checks of the glyph mask format converter
// depends on the top level's ports; bound to it at the end of this file

module gmfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        pready
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds its transaction
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast))
        else $error("stalled result changed");

    // with the result register empty the pipeline must take input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input not ready with empty output");

    // the top byte is zero or the opaque alpha
    a_alpha_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[31:24] == 8'd0)
            || (o_m_tdata[31:24] == gmfc_pkg::ALPHA_OPAQUE))
        else $error("bad alpha byte");

    // configuration port has no wait states
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind glyph_mask_format_converter gmfc_checker u_gmfc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .pready     (pready)
);
